/* rtl/core/ksat_pkg.sv */
// shared types and codes for the keyed sequence aging table
package ksat_pkg;

  typedef enum logic [1:0] {
    CMD_UPSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PRUNE  = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_STALE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // one stored record
  typedef struct packed {
    logic [31:0] user_key;
    logic [31:0] client_key;
    logic [31:0] sequence_num;
    logic [63:0] time_ms;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] user_key;
    logic [31:0] client_key;
    logic [31:0] update_sequence;
    logic [63:0] time_ms;
    logic [31:0] entry_payload;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] found_sequence;
    logic [63:0] found_time_ms;
    logic [31:0] found_payload;
    logic [4:0]  pruned_count;
    logic [31:0] table_revision;
    logic [4:0]  entry_count;
  } result_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic aged;
  } cmp_flags_t;

endpackage

/* rtl/core/ksat_store.sv */
// record memory: one write port, one registered read port
module ksat_store
  import ksat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr_i,
  input  entry_t                                 wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr_i,
  output entry_t                                 rd_data_o
);

  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/ksat_cmp.sv */
// shared compare unit: key match and age test against one record
module ksat_cmp
  import ksat_pkg::*;
(
  input  entry_t      entry_i,
  input  logic [31:0] user_key_i,
  input  logic [31:0] client_key_i,
  input  logic [63:0] now_i,
  input  logic [31:0] timeout_i,
  output cmp_flags_t  flags_o
);

  logic [64:0] age;

  // top bit set means now is before the last update
  assign age = {1'b0, now_i} - {1'b0, entry_i.time_ms};

  assign flags_o.key_eq = (entry_i.user_key == user_key_i) &&
                          (entry_i.client_key == client_key_i);
  assign flags_o.aged   = (timeout_i != 32'd0) && !age[64] &&
                          (age[63:0] >= {32'd0, timeout_i});

endmodule

/* rtl/core/ksat_ctrl.sv */
// command sequencer: scans the table one record a cycle, then commits
module ksat_ctrl
  import ksat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   item_valid_i,
  input  item_t                                  item_i,
  output logic                                   item_ready_o,
  output logic                                   rd_en_o,
  output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr_o,
  input  entry_t                                 rd_data_i,
  output logic                                   wr_en_o,
  output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr_o,
  output entry_t                                 wr_data_o,
  output item_t                                  item_o,
  input  cmp_flags_t                             flags_i,
  input  logic                                   out_free_i,
  output logic                                   done_o,
  output result_t                                result_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;
  logic [IW-1:0] addr_q, addr_d;
  logic          p_vld_q, p_vld_d;
  logic [IW-1:0] p_idx_q, p_idx_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  entry_t        hit_entry_q, hit_entry_d;
  logic          free_found_q, free_found_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [CW-1:0] pruned_q, pruned_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   rev_q, rev_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic          ent_v;
  logic          key_zero;
  logic [CW+4:0] pruned_ext, count_ext;

  assign item_o       = item_q;
  assign item_ready_o = (state_q == S_IDLE);
  assign ent_v        = valid_q[p_idx_q];
  assign key_zero     = (item_q.user_key == 32'd0) || (item_q.client_key == 32'd0);
  assign pruned_ext   = {5'd0, pruned_q};
  assign count_ext    = {5'd0, count_d};

  assign wr_data_o.user_key     = item_q.user_key;
  assign wr_data_o.client_key   = item_q.client_key;
  assign wr_data_o.sequence_num = item_q.update_sequence;
  assign wr_data_o.time_ms      = item_q.time_ms;
  assign wr_data_o.payload      = item_q.entry_payload;

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    p_vld_d      = 1'b0;
    p_idx_d      = addr_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_entry_d  = hit_entry_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    pruned_d     = pruned_q;
    count_d      = count_q;
    rev_d        = rev_q;
    valid_d      = valid_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = addr_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = hit_idx_q;
    done_o       = 1'b0;

    // compare stage, in the cycle after the memory read
    if (p_vld_q) begin
      if (item_q.command == CMD_PRUNE) begin
        if (ent_v && flags_i.aged) begin
          valid_d[p_idx_q] = 1'b0;
          count_d          = count_q - CW'(1);
          pruned_d         = pruned_q + CW'(1);
        end
      end else if (ent_v && flags_i.key_eq && !hit_q) begin
        hit_d       = 1'b1;
        hit_idx_d   = p_idx_q;
        hit_entry_d = rd_data_i;
      end
      if (!ent_v && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = p_idx_q;
      end
    end

    result_o.status         = ST_OK;
    result_o.found_sequence = 32'd0;
    result_o.found_time_ms  = 64'd0;
    result_o.found_payload  = 32'd0;
    result_o.pruned_count   = pruned_ext[4:0];

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          state_d      = S_SCAN;
          addr_d       = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          pruned_d     = '0;
        end
      end
      S_SCAN: begin
        rd_en_o = 1'b1;
        p_vld_d = 1'b1;
        if (addr_q == LastIdx) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + IW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
          unique case (item_q.command)
            CMD_UPSERT: begin
              if (key_zero) begin
                result_o.status = ST_INVALID;
              end else if (hit_q) begin
                if (item_q.update_sequence < hit_entry_q.sequence_num) begin
                  result_o.status = ST_STALE;
                end else begin
                  wr_en_o = 1'b1;
                  rev_d   = rev_q + 32'd1;
                end
              end else if (count_q == FullCnt) begin
                result_o.status = ST_FULL;
              end else begin
                wr_en_o             = 1'b1;
                wr_addr_o           = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                count_d             = count_q + CW'(1);
                rev_d               = rev_q + 32'd1;
              end
            end
            CMD_REMOVE: begin
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
                count_d            = count_q - CW'(1);
                rev_d              = rev_q + 32'd1;
              end else begin
                result_o.status = ST_NOT_FOUND;
              end
            end
            CMD_PRUNE: begin
              if (pruned_q != '0) begin
                rev_d = rev_q + 32'd1;
              end
            end
            CMD_FIND: begin
              if (hit_q) begin
                result_o.found_sequence = hit_entry_q.sequence_num;
                result_o.found_time_ms  = hit_entry_q.time_ms;
                result_o.found_payload  = hit_entry_q.payload;
              end else begin
                result_o.status = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    result_o.table_revision = rev_d;
    result_o.entry_count    = count_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_vld_q      <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      pruned_q     <= '0;
      count_q      <= '0;
      rev_q        <= 32'd0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      p_vld_q      <= p_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      pruned_q     <= pruned_d;
      count_q      <= count_d;
      rev_q        <= rev_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      item_q <= item_i;
    end
    addr_q      <= addr_d;
    p_idx_q     <= p_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_entry_q <= hit_entry_d;
    free_idx_q  <= free_idx_d;
  end

endmodule

/* rtl/core/keyed_sequence_aging_table.sv */
// top level of the keyed sequence aging table
//
// Holds up to MAX_ENTRIES records keyed by (user, client), each with a
// sequence, a last-update time and a payload. Every command beat on the slave
// side gives exactly one result beat on the master side. The block takes no
// new command until the current one is done: the record memory has one read
// port, so the sequencer walks the table one record a cycle through the shared
// key/age compare unit, then drains the read pipeline and then commits the
// write and the result. A finished result waits in the output register while
// the next command is taken; the commit step stalls only if that register is
// still full. The user must write aging_timeout_ms through cfg_we_i only while
// the block is idle; the block itself does not enforce this. No clearing pass
// is needed after reset.
module keyed_sequence_aging_table
  import ksat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,     // aging_timeout_ms
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [191:0] s_axis_tdata_i,  // user_key, client_key, update_sequence,
                                        // time_ms, entry_payload
  input  logic [1:0]   s_axis_tuser_i,  // command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [175:0] m_axis_tdata_o,  // found_sequence, found_time_ms,
                                        // found_payload, pruned_count,
                                        // table_revision, entry_count, zero pad
  output logic [2:0]   m_axis_tuser_o   // status
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [31:0] timeout_q;
  item_t       item_in, item_cur;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  cmp_flags_t    flags;
  logic          out_free, done;
  result_t       result;
  logic          out_valid_q;
  result_t       out_q;

  assign item_in.command         = cmd_e'(s_axis_tuser_i);
  assign item_in.user_key        = s_axis_tdata_i[31:0];
  assign item_in.client_key      = s_axis_tdata_i[63:32];
  assign item_in.update_sequence = s_axis_tdata_i[95:64];
  assign item_in.time_ms         = s_axis_tdata_i[159:96];
  assign item_in.entry_payload   = s_axis_tdata_i[191:160];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd0;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  ksat_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ksat_cmp u_cmp (
    .entry_i      (rd_data),
    .user_key_i   (item_cur.user_key),
    .client_key_i (item_cur.client_key),
    .now_i        (item_cur.time_ms),
    .timeout_i    (timeout_q),
    .flags_o      (flags)
  );

  ksat_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_i       (item_in),
    .item_ready_o (s_axis_tready_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .item_o       (item_cur),
    .flags_i      (flags),
    .out_free_i   (out_free),
    .done_o       (done),
    .result_o     (result)
  );

  // output register parts the result beat from the scan
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {6'd0, out_q.entry_count, out_q.table_revision,
                            out_q.pruned_count, out_q.found_payload,
                            out_q.found_time_ms, out_q.found_sequence};

endmodule

/* rtl/core/ksat_checker.sv */
// port-level checks for the keyed sequence aging table, bound to the top level
module ksat_checker
  import ksat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [175:0] m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o
);

  // a held result beat keeps its contents
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // every command walks the table, so no beat follows right behind another
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted back to back");

  // only a successful find carries record contents
  a_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |-> m_axis_tdata_o[127:0] == 128'd0)
    else $error("record fields set on a failed command");

  // a beat with a nonzero pruned count always reports ok
  a_prune_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[132:128] != 5'd0 |-> m_axis_tuser_o == ST_OK)
    else $error("entries dropped by a failed command");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (MAX_ENTRIES > 31) ||
      (m_axis_tdata_o[169:165] <= 5'(MAX_ENTRIES)))
    else $error("entry count beyond table size");

endmodule

bind keyed_sequence_aging_table ksat_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_ksat_checker (.*);
